>>> src/slid_pkg.sv
// Package for the sorted list block: shared types, field widths and codes.
// No dependencies; used by slid_cell and sorted_list_insert_delete_top.
package slid_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int CNT_W   = 5;

   typedef enum logic {
      ACT_INSERT = 1'b0,
      ACT_DELETE = 1'b1
   } act_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_PEND
   } fsm_type;

   // Operation token handed from cell to cell.
   typedef struct packed {
      act_type                    act;
      logic signed [VALUE_W-1:0]  value;
      logic signed [VALUE_W-1:0]  carry;      // entry being pushed up on insert
      logic                       carry_vld;
      logic                       hit;        // placed (insert) or found (delete)
      logic        [POS_W-1:0]    pos;
   } wave_type;

endpackage

>>> src/slid_cell.sv
// One list cell: holds one entry and its valid bit, works on the token
// passing by and hands it on. Depends on slid_pkg.
module slid_cell
   import slid_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  wave_type                  tok_i,
   input  logic                      tok_vld_i,
   input  logic signed [VALUE_W-1:0] nxt_val_i,
   input  logic                      nxt_vld_i,
   output logic signed [VALUE_W-1:0] val_o,
   output logic                      vld_o,
   output wave_type                  tok_o,
   output logic                      tok_vld_o
);

   logic signed [VALUE_W-1:0] val_ff, val_in;
   logic                      vld_ff, vld_in;
   wave_type                  tok_ff, tok_in;
   logic                      tok_vld_ff;

   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      tok_in = tok_i;
      if (tok_vld_i) begin
         if (tok_i.act == ACT_INSERT) begin
            if (!tok_i.hit) begin
               // first entry greater than the value, or first free slot
               if (!vld_ff || (tok_i.value < val_ff)) begin
                  val_in           = tok_i.value;
                  vld_in           = 1'b1;
                  tok_in.hit       = 1'b1;
                  tok_in.pos       = POS_W'(IDX);
                  tok_in.carry     = val_ff;
                  tok_in.carry_vld = vld_ff;
               end
            end else if (tok_i.carry_vld) begin
               val_in           = tok_i.carry;
               vld_in           = 1'b1;
               tok_in.carry     = val_ff;
               tok_in.carry_vld = vld_ff;
            end
         end else begin
            if (!tok_i.hit && vld_ff && (val_ff == tok_i.value)) begin
               tok_in.hit = 1'b1;
               tok_in.pos = POS_W'(IDX);
            end
            // close the gap: pull the right neighbor's entry
            if (tok_in.hit) begin
               val_in = nxt_val_i;
               vld_in = nxt_vld_i;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      tok_ff <= tok_in;
      if (reset) begin
         vld_ff     <= 1'b0;
         tok_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= vld_in;
         tok_vld_ff <= tok_vld_i;
      end
   end

   assign val_o     = val_ff;
   assign vld_o     = vld_ff;
   assign tok_o     = tok_ff;
   assign tok_vld_o = tok_vld_ff;

endmodule

>>> src/sorted_list_insert_delete_top.sv
// Sorted list of up to CAPACITY signed 32-bit values in ascending order.
// Each item on req_ is an insert (tuser 0) or a delete of the first equal
// entry (tuser 1) and gives exactly one result item on rsp_. The list lives
// in a row of CAPACITY cells; an accepted operation travels along the row as
// a token, one cell per cycle, each cell inserting, shifting up or pulling
// its right neighbor's entry down as the token passes. One item is in work
// at a time: a successful or not-found operation walks the whole cell row,
// then the pending state loads the result register and returns to idle;
// an insert into a full list or a delete from an empty list is answered
// without a walk and goes straight to the pending state. The pending state
// is held for as long as the previous result still waits on rsp_tready.
// The result register lets the next item in while the previous result
// still waits on rsp_tready.
// Depends on slid_pkg and slid_cell.
module sorted_list_insert_delete_top
   import slid_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request side
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value (signed)
   input  logic        req_tuser,   // [0] action: 0 insert, 1 delete
   // result side
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [5:2] position,
                                    // [10:6] count, [11] is_empty,
                                    // [12] is_full, [15:13] zero
);

   localparam int CNT_BITS = $clog2(CAPACITY + 1);
   localparam logic [CNT_BITS-1:0] CAP_CNT = CNT_BITS'(CAPACITY);

   // ---------------------------------------------------------------
   // Cell row
   // ---------------------------------------------------------------
   wave_type                  tok     [CAPACITY+1];
   logic                      tok_vld [CAPACITY+1];
   logic signed [VALUE_W-1:0] cell_val [CAPACITY+1];
   logic                      cell_vld [CAPACITY+1];

   // beyond the last cell: nothing to pull in
   assign cell_val[CAPACITY] = '0;
   assign cell_vld[CAPACITY] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         slid_cell #(
            .IDX (gi)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .tok_i     (tok[gi]),
            .tok_vld_i (tok_vld[gi]),
            .nxt_val_i (cell_val[gi+1]),
            .nxt_vld_i (cell_vld[gi+1]),
            .val_o     (cell_val[gi]),
            .vld_o     (cell_vld[gi]),
            .tok_o     (tok[gi+1]),
            .tok_vld_o (tok_vld[gi+1])
         );
      end
   endgenerate

   // ---------------------------------------------------------------
   // Control
   // ---------------------------------------------------------------
   fsm_type             state_ff, state_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   status_type          res_status_ff, res_status_in;
   logic [POS_W-1:0]    res_pos_ff, res_pos_in;
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]         rsp_tdata_ff, rsp_tdata_in;

   act_type  req_act;
   logic     accept;
   logic     refuse_full;
   logic     refuse_empty;
   logic     refuse;
   logic     launch;
   logic     rsp_free;
   logic     load_rsp;
   wave_type tail;
   logic     tail_vld;

   assign req_act      = act_type'(req_tuser);
   assign accept       = req_tvalid && req_tready;
   assign refuse_full  = (req_act == ACT_INSERT) && (count_ff == CAP_CNT);
   assign refuse_empty = (req_act == ACT_DELETE) && (count_ff == '0);
   assign refuse       = refuse_full || refuse_empty;
   assign rsp_free     = !rsp_tvalid_ff || rsp_tready;
   assign tail         = tok[CAPACITY];
   assign tail_vld     = tok_vld[CAPACITY];

   // token entering the first cell
   assign tok[0].act       = req_act;
   assign tok[0].value     = req_tdata;
   assign tok[0].carry     = '0;
   assign tok[0].carry_vld = 1'b0;
   assign tok[0].hit       = 1'b0;
   assign tok[0].pos       = '0;
   assign tok_vld[0]       = launch;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               state_in = refuse ? FSM_PEND : FSM_WALK;
            end
         end
         FSM_WALK: begin
            if (tail_vld) begin
               state_in = FSM_PEND;
            end
         end
         FSM_PEND: begin
            if (rsp_free) begin
               state_in = FSM_IDLE;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_tready = 1'b0;
      launch     = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_tready = 1'b1;
            launch     = req_tvalid && !refuse;
         end
         FSM_PEND: begin
            load_rsp = rsp_free;
         end
         default: ;
      endcase
   end

   // result and count
   always_comb begin
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_pos_in    = res_pos_ff;
      if (accept && refuse) begin
         res_status_in = refuse_full ? ST_FULL : ST_EMPTY;
         res_pos_in    = '0;
      end else if ((state_ff == FSM_WALK) && tail_vld) begin
         if (tail.act == ACT_INSERT) begin
            res_status_in = ST_DONE;
            res_pos_in    = tail.pos;
            count_in      = count_ff + 1'b1;
         end else if (tail.hit) begin
            res_status_in = ST_DONE;
            res_pos_in    = tail.pos;
            count_in      = count_ff - 1'b1;
         end else begin
            res_status_in = ST_NOT_FOUND;
            res_pos_in    = '0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      if (load_rsp) begin
         rsp_tvalid_in       = 1'b1;
         rsp_tdata_in        = '0;
         rsp_tdata_in[1:0]   = res_status_ff;
         rsp_tdata_in[5:2]   = res_pos_ff;
         rsp_tdata_in[10:6]  = CNT_W'(count_ff);
         rsp_tdata_in[11]    = (count_ff == '0);
         rsp_tdata_in[12]    = (count_ff == CAP_CNT);
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_pos_ff    <= res_pos_in;
      rsp_tdata_ff  <= rsp_tdata_in;
      if (reset) begin
         state_ff      <= FSM_IDLE;
         count_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // a token leaves the row only while a walk is in progress
   a_tail_in_walk : assert property (@(posedge clock) disable iff (reset)
      tail_vld |-> (state_ff == FSM_WALK))
      else $error("token left the cell row outside a walk");

   // the count never exceeds the capacity
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_CNT)
      else $error("entry count above capacity");

   // between operations the first cell is occupied exactly when the list is not empty
   a_head_matches_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_IDLE) |-> (cell_vld[0] == (count_ff != '0)))
      else $error("first cell valid bit disagrees with count");

   // an operation that needs a walk launches exactly one token
   a_launch_walk : assert property (@(posedge clock) disable iff (reset)
      launch |=> ((state_ff == FSM_WALK) && tok_vld[1]))
      else $error("launched token not seen in first cell");

endmodule

>>> bench/tb_sorted_list_insert_delete_top.sv
// Self-checking bench for sorted_list_insert_delete_top: a shadow copy of the list
// predicts status, position and count of every item. Random traffic and back-pressure.
// Depends on slid_pkg and the RTL under src/.
module tb_sorted_list_insert_delete_top;
   import slid_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 16;
   localparam int RAND_ITEMS = 900;
   localparam int HOLD_LEN   = 300;   // long receiver hold-off, in cycles
   localparam int IDLE_PCT   = 28;

   // result word as it sits on rsp_tdata, lowest field last
   typedef struct packed {
      logic [2:0]       pad;
      logic             is_full;
      logic             is_empty;
      logic [CNT_W-1:0] count;
      logic [POS_W-1:0] position;
      status_type       status;
   } rsp_word_type;

   // Shadow list plus the queue of results still owed by the block.
   class sorted_list_tracker;
      logic signed [VALUE_W-1:0] held[$];
      rsp_word_type              owed[$];
      int unsigned               errors;

      function new();
         errors = 0;
      endfunction

      // apply one accepted operation to the shadow list, queue its result
      function void note_op(act_type act, logic signed [VALUE_W-1:0] value);
         rsp_word_type r;
         int           idx;
         r = '0;
         r.status = ST_DONE;
         idx = 0;
         if (act == ACT_INSERT) begin
            if (held.size() >= DEPTH) begin
               r.status = ST_FULL;
            end else begin
               // goes after every entry not greater than it
               while (idx < held.size() && held[idx] <= value) idx++;
               held.insert(idx, value);
            end
         end else begin
            if (held.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               while (idx < held.size() && held[idx] != value) idx++;
               if (idx == held.size()) begin
                  r.status = ST_NOT_FOUND;
                  idx = 0;
               end else begin
                  held.delete(idx);
               end
            end
         end
         r.position = idx[POS_W-1:0];
         r.count    = CNT_W'(held.size());
         r.is_empty = (held.size() == 0);
         r.is_full  = (held.size() == DEPTH);
         owed.push_back(r);
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_result(rsp_word_type got);
         rsp_word_type want;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t ns: result with none expected, expected nothing, actual %h",
                     $time, got);
            return;
         end
         want = owed.pop_front();
         compare_field("status",   8'(want.status),   8'(got.status));
         compare_field("position", 8'(want.position), 8'(got.position));
         compare_field("count",    8'(want.count),    8'(got.count));
         compare_field("is_empty", 8'(want.is_empty), 8'(got.is_empty));
         compare_field("is_full",  8'(want.is_full),  8'(got.is_full));
         compare_field("pad",      8'(want.pad),      8'(got.pad));
      endfunction

      // some value currently in the list, for deletes that should hit
      function logic signed [VALUE_W-1:0] pick_held();
         if (held.size() == 0) return $urandom;
         return held[$urandom_range(0, held.size() - 1)];
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] value (signed)
   logic        req_tuser = 1'b0; // [0] action: 0 insert, 1 delete
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;        // [1:0] status, [5:2] position, [10:6] count,
                                  // [11] is_empty, [12] is_full, [15:13] zero

   // sender and receiver pacing, shared with the receiver process
   bit gaps_on   = 1'b1;
   bit rx_steady = 1'b0;
   bit hold_req  = 1'b0;

   sorted_list_tracker tracker = new();

   sorted_list_insert_delete_top #(.CAPACITY(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: far above the slowest legal run (about 935 items, each at most a
   // full row walk plus stalls).
   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Both handshakes are observed at the rising edge, before the block's
   // registers move; the request is noted first so a same-edge result sees it.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_op(act_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready)
            tracker.check_result(rsp_word_type'(rsp_tdata));
      end
   end

   // Receiver: random stalls, a steady stretch, and one long hold-off on request.
   // The hold-off is counted here so the sender keeps pushing meanwhile and the
   // block's result register fills up, which must back-pressure req_tready.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN - 1) @(negedge clock);
            hold_req = 1'b0;
         end else if (rx_steady) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   // One item on req_: optional idle cycles, then hold valid until accepted.
   // Entered and left at a falling edge, so valid is never dropped and
   // raised again within one time step.
   task automatic send_op(act_type act, logic signed [VALUE_W-1:0] value);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         req_tdata  <= $urandom;   // junk while idle
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tuser  <= act;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // small values collide often, which exercises duplicates and delete hits
   function automatic logic signed [VALUE_W-1:0] small_value();
      return int'($urandom_range(0, 15)) - 8;
   endfunction

   function automatic logic signed [VALUE_W-1:0] insert_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return small_value();
      if (roll < 65) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return -1;
            default: return 0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic logic signed [VALUE_W-1:0] delete_value();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return tracker.pick_held();
      if (roll < 80) return small_value();
      return $urandom;
   endfunction

   initial begin
      int insert_pct;
      int phase_left;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: delete on empty, extremes, duplicate ordering, miss, hits.
      send_op(ACT_DELETE, 5);                 // empty, refused
      send_op(ACT_INSERT, 32'h7FFF_FFFF);
      send_op(ACT_INSERT, 32'h8000_0000);
      send_op(ACT_INSERT, 0);
      send_op(ACT_INSERT, -1);
      send_op(ACT_INSERT, 0);                 // equal value lands after the first 0
      send_op(ACT_INSERT, -1);
      send_op(ACT_INSERT, 5);
      send_op(ACT_DELETE, 3);                 // not found
      send_op(ACT_DELETE, -1);                // first of two equal entries
      send_op(ACT_DELETE, 32'h8000_0000);     // head of the list
      send_op(ACT_DELETE, 32'h7FFF_FFFF);     // tail of the list
      send_op(ACT_DELETE, 0);
      send_op(ACT_DELETE, 0);
      send_op(ACT_DELETE, -1);
      send_op(ACT_DELETE, 5);                 // list empty again
      send_op(ACT_DELETE, -1);                // empty, refused
      // fill to full and try one more, then drain one
      for (int i = 0; i < DEPTH; i++) send_op(ACT_INSERT, small_value());
      send_op(ACT_INSERT, 1);                 // full, refused
      send_op(ACT_DELETE, tracker.pick_held());

      // Random: phases lean toward insert or delete so the list swings
      // between empty and full and both refusals show up.
      insert_pct = 50;
      phase_left = 0;
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
               0: insert_pct = 80;
               1: insert_pct = 20;
               default: insert_pct = 50;
            endcase
         end
         phase_left--;
         if (n == 200) hold_req = 1'b1;
         if (n == 400) begin
            gaps_on   = 1'b0;
            rx_steady = 1'b1;
         end
         if (n == 550) begin
            gaps_on   = 1'b1;
            rx_steady = 1'b0;
         end
         if ($urandom_range(0, 99) < insert_pct)
            send_op(ACT_INSERT, insert_value());
         else
            send_op(ACT_DELETE, delete_value());
      end
      req_tvalid <= 1'b0;

      // drain, then allow a full row walk plus margin for anything stray
      while (tracker.owed.size() != 0) @(posedge clock);
      repeat (4 * (DEPTH + 3)) @(posedge clock);
      if (tracker.errors == 0 && tracker.owed.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
